@@ design/iirdf1_pkg.sv @@
// Package of the direct form I filter: field widths, action and register codes,
// and the control bundle for the multiply-accumulate unit.
// Used by the interfaces and by every module of the block.
package iirdf1_pkg;

    localparam int MAX_ORDER_DEF = 8;
    localparam int DATA_W        = 32;
    localparam int ACC_W         = 64;
    localparam int ORDER_W       = 4;
    localparam int ACTION_W      = 2;
    localparam int CIDX_IN_W     = 4;
    localparam int CFG_IDX_W     = 2;

    localparam logic [ACTION_W-1:0] ACT_SAMPLE   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_NUM_COEF = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DEN_COEF = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ORDER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEN_ORDER = 2'd1;

    typedef struct packed {
        logic clr;
        logic vld;
        logic sub;
    } t_mac_ctl;

endpackage

@@ design/iirdf1_if.sv @@
// Valid/ready channels of the direct form I filter: configuration writes,
// input items and result items. Depends on iirdf1_pkg for the field widths.
interface iirdf1_cfg_if;
    import iirdf1_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [ORDER_W-1:0]   data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

interface iirdf1_in_if;
    import iirdf1_pkg::*;
    logic                        valid;
    logic                        ready;
    logic [ACTION_W-1:0]         action;
    logic [CIDX_IN_W-1:0]        coef_index;
    logic signed [DATA_W-1:0]    value;
    modport source (output valid, action, coef_index, value, input ready);
    modport sink (input valid, action, coef_index, value, output ready);
endinterface

interface iirdf1_out_if;
    import iirdf1_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] filtered;
    logic                     saturated;
    logic                     zero_divisor;
    modport source (output valid, filtered, saturated, zero_divisor, input ready);
    modport sink (input valid, filtered, saturated, zero_divisor, output ready);
endinterface

@@ design/iirdf1_ram.sv @@
// Synchronous RAM with one write port, one registered read port and a valid
// bit per entry, so that entries never written read as zero after reset.
// Depends on iirdf1_pkg for the data width.
module iirdf1_ram #(
    parameter int DEPTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_we,
    input  logic [$clog2(DEPTH)-1:0]          i_waddr,
    input  logic [iirdf1_pkg::DATA_W-1:0]     i_wdata,
    input  logic [$clog2(DEPTH)-1:0]          i_raddr,
    output logic [iirdf1_pkg::DATA_W-1:0]     o_rdata
);
    import iirdf1_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]  r_vld;
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_vld[i_raddr] ? r_mem[i_raddr] : '0;
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/iirdf1_mac.sv @@
// Multiply-accumulate unit: a registered 32 by 32 product followed by a
// 64-bit wrapping accumulator that adds or subtracts it.
// Depends on iirdf1_pkg for widths and the control bundle.
module iirdf1_mac (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  iirdf1_pkg::t_mac_ctl                  i_ctl,
    input  logic signed [iirdf1_pkg::DATA_W-1:0]  i_coef,
    input  logic signed [iirdf1_pkg::DATA_W-1:0]  i_data,
    output logic [iirdf1_pkg::ACC_W-1:0]          o_acc,
    output logic                                  o_busy
);
    import iirdf1_pkg::*;

    logic signed [ACC_W-1:0] r_prod;
    logic                    r_prod_vld;
    logic                    r_prod_sub;
    logic [ACC_W-1:0]        r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod     <= ACC_W'(i_coef) * ACC_W'(i_data);
        r_prod_sub <= i_ctl.sub;
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_prod_sub ? r_acc - r_prod : r_acc + r_prod;
        end
    end

    assign o_acc  = r_acc;
    assign o_busy = r_prod_vld;

endmodule

@@ design/iirdf1_div.sv @@
// Restoring divider of a 64-bit magnitude by a 32-bit magnitude, one quotient
// bit per cycle. Depends on iirdf1_pkg for the widths.
module iirdf1_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [iirdf1_pkg::ACC_W-1:0]   i_dividend,
    input  logic [iirdf1_pkg::DATA_W-1:0]  i_divisor,
    output logic                           o_done,
    output logic [iirdf1_pkg::ACC_W-1:0]   o_quotient
);
    import iirdf1_pkg::*;

    localparam int CNT_W = $clog2(ACC_W + 1);

    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DATA_W-1:0] r_rem;
    logic [ACC_W-1:0]  r_quo;
    logic [DATA_W-1:0] r_div;
    logic [DATA_W:0]   trial;
    logic              fits;

    assign trial = {r_rem, r_quo[ACC_W-1]};
    assign fits  = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ACC_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? DATA_W'(trial - {1'b0, r_div}) : DATA_W'(trial);
            r_quo <= {r_quo[ACC_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

@@ design/iir_direct_form_one_unit.sv @@
// Top level of the direct form I filter: sequencer, coefficient and history
// RAMs, multiply-accumulate unit and divider. Depends on iirdf1_pkg,
// iirdf1_if, iirdf1_ram, iirdf1_mac and iirdf1_div.
//
// Channels: i_cfg writes the numerator and denominator orders (index 0 and 1)
// and is always ready. i_in carries items: a sample, or a write of a numerator
// or denominator coefficient. o_out carries one result item per sample.
// A coefficient write gives no result.
// A sample goes from acceptance to a valid result through one coefficient
// RAM read per tap, for a0, b0 and the nn and nd taps of the clamped orders, a
// drain of the multiply-accumulate pipeline, the bit-serial divider and two
// history write-backs through the single RAM write port. With a zero a0 the
// divider and the history write-backs are skipped.
// One item is worked on at a time; the next is accepted the cycle after the
// result has been placed in the output register.
// Reset clears the orders and the ring position, and all coefficients and both
// histories at once through per-entry valid bits; no clearing pass is needed.
// When the receiver stalls, the result waits in the output register while a
// new item is still accepted; a second result waits until the first is taken.
module iir_direct_form_one_unit #(
    parameter int MAX_ORDER = iirdf1_pkg::MAX_ORDER_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    iirdf1_cfg_if.sink          i_cfg,
    iirdf1_in_if.sink           i_in,
    iirdf1_out_if.source        o_out
);
    import iirdf1_pkg::*;

    localparam int CIDX_W  = $clog2(MAX_ORDER + 1);
    localparam int POS_W   = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int CDEPTH  = 2 * (MAX_ORDER + 1);
    localparam int HDEPTH  = 2 * MAX_ORDER;
    localparam int CA_W    = $clog2(CDEPTH);
    localparam int HA_W    = $clog2(HDEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_A0, S_B0, S_NUM, S_DEN, S_DRAIN, S_DIV, S_WBX, S_WBY, S_OUT
    } t_state;

    typedef enum logic [1:0] {
        TAP_A0, TAP_B0, TAP_NUM, TAP_DEN
    } t_tap;

    function automatic logic [CA_W-1:0] coef_addr(input logic den, input int idx);
        return CA_W'(den ? idx + MAX_ORDER + 1 : idx);
    endfunction

    function automatic logic [HA_W-1:0] hist_addr(input logic outs, input int idx);
        return HA_W'(outs ? idx + MAX_ORDER : idx);
    endfunction

    function automatic logic [CIDX_W-1:0] clamp_order(input logic [ORDER_W-1:0] ord);
        return (int'(ord) > MAX_ORDER) ? CIDX_W'(MAX_ORDER) : CIDX_W'(ord);
    endfunction

    function automatic logic [POS_W-1:0] ring_dec(input logic [POS_W-1:0] p);
        return (p == '0) ? POS_W'(MAX_ORDER - 1) : p - POS_W'(1);
    endfunction

    t_state                   r_state, n_state;
    logic [ORDER_W-1:0]       r_num_ord, n_num_ord;
    logic [ORDER_W-1:0]       r_den_ord, n_den_ord;
    logic signed [DATA_W-1:0] r_sample, n_sample;
    logic [CIDX_W-1:0]        r_k, n_k;
    logic [POS_W-1:0]         r_hidx, n_hidx;
    logic [POS_W-1:0]         r_pos, n_pos;
    logic                     r_rd_vld, n_rd_vld;
    t_tap                     r_rd_kind, n_rd_kind;
    logic [DATA_W-1:0]        r_a0, n_a0;
    logic                     r_neg, n_neg;
    logic [DATA_W-1:0]        r_y, n_y;
    logic                     r_sat, n_sat;
    logic                     r_zdiv, n_zdiv;
    logic                     r_out_vld, n_out_vld;
    logic [DATA_W-1:0]        r_out_y, n_out_y;
    logic                     r_out_sat, n_out_sat;
    logic                     r_out_zdiv, n_out_zdiv;

    logic              in_acc;
    logic [CIDX_W-1:0] nn, nd;
    logic              c_we;
    logic [CA_W-1:0]   c_waddr, c_raddr;
    logic [DATA_W-1:0] c_rdata;
    logic              h_we;
    logic [HA_W-1:0]   h_waddr, h_raddr;
    logic [DATA_W-1:0] h_wdata, h_rdata;
    t_mac_ctl          mac_ctl;
    logic [ACC_W-1:0]  acc;
    logic              mac_busy;
    logic              div_start;
    logic [ACC_W-1:0]  div_dividend;
    logic [DATA_W-1:0] div_divisor;
    logic              div_done;
    logic [ACC_W-1:0]  quo;

    assign in_acc = i_in.valid && i_in.ready;
    assign nn     = clamp_order(r_num_ord);
    assign nd     = clamp_order(r_den_ord);

    assign c_we = in_acc && (i_in.action == ACT_NUM_COEF || i_in.action == ACT_DEN_COEF)
                  && int'(i_in.coef_index) <= MAX_ORDER;
    assign c_waddr = coef_addr(i_in.action == ACT_DEN_COEF, int'(i_in.coef_index));

    assign mac_ctl.clr = in_acc && i_in.action == ACT_SAMPLE;
    assign mac_ctl.vld = r_rd_vld && r_rd_kind != TAP_A0;
    assign mac_ctl.sub = r_rd_kind == TAP_DEN;

    assign div_dividend = acc[ACC_W-1] ? ACC_W'(0) - acc : acc;
    assign div_divisor  = r_a0[DATA_W-1] ? DATA_W'(0) - r_a0 : r_a0;

    always_comb begin
        n_state    = r_state;
        n_num_ord  = r_num_ord;
        n_den_ord  = r_den_ord;
        n_sample   = r_sample;
        n_k        = r_k;
        n_hidx     = r_hidx;
        n_pos      = r_pos;
        n_rd_vld   = 1'b0;
        n_rd_kind  = r_rd_kind;
        n_a0       = r_a0;
        n_neg      = r_neg;
        n_y        = r_y;
        n_sat      = r_sat;
        n_zdiv     = r_zdiv;
        n_out_vld  = r_out_vld && !o_out.ready;
        n_out_y    = r_out_y;
        n_out_sat  = r_out_sat;
        n_out_zdiv = r_out_zdiv;
        c_raddr    = coef_addr(1'b1, 0);
        h_raddr    = hist_addr(1'b0, int'(r_hidx));
        h_we       = 1'b0;
        h_waddr    = hist_addr(1'b0, int'(r_pos));
        h_wdata    = r_sample;
        div_start  = 1'b0;

        if (i_cfg.valid) begin
            if (i_cfg.index == CFG_NUM_ORDER) begin
                n_num_ord = i_cfg.data;
            end else if (i_cfg.index == CFG_DEN_ORDER) begin
                n_den_ord = i_cfg.data;
            end
        end

        if (r_rd_vld && r_rd_kind == TAP_A0) begin
            n_a0 = c_rdata;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc && i_in.action == ACT_SAMPLE) begin
                    n_sample = i_in.value;
                    n_state  = S_A0;
                end
            end
            S_A0: begin
                c_raddr   = coef_addr(1'b1, 0);
                n_rd_vld  = 1'b1;
                n_rd_kind = TAP_A0;
                n_state   = S_B0;
            end
            S_B0: begin
                c_raddr   = coef_addr(1'b0, 0);
                n_rd_vld  = 1'b1;
                n_rd_kind = TAP_B0;
                n_k       = CIDX_W'(1);
                n_hidx    = ring_dec(r_pos);
                if (nn != '0) begin
                    n_state = S_NUM;
                end else if (nd != '0) begin
                    n_state = S_DEN;
                end else begin
                    n_state = S_DRAIN;
                end
            end
            S_NUM: begin
                c_raddr   = coef_addr(1'b0, int'(r_k));
                h_raddr   = hist_addr(1'b0, int'(r_hidx));
                n_rd_vld  = 1'b1;
                n_rd_kind = TAP_NUM;
                n_k       = r_k + CIDX_W'(1);
                n_hidx    = ring_dec(r_hidx);
                if (r_k == nn) begin
                    n_k    = CIDX_W'(1);
                    n_hidx = ring_dec(r_pos);
                    n_state = (nd != '0) ? S_DEN : S_DRAIN;
                end
            end
            S_DEN: begin
                c_raddr   = coef_addr(1'b1, int'(r_k));
                h_raddr   = hist_addr(1'b1, int'(r_hidx));
                n_rd_vld  = 1'b1;
                n_rd_kind = TAP_DEN;
                n_k       = r_k + CIDX_W'(1);
                n_hidx    = ring_dec(r_hidx);
                if (r_k == nd) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_rd_vld && !mac_busy) begin
                    if (r_a0 == '0) begin
                        n_y     = '0;
                        n_sat   = 1'b0;
                        n_zdiv  = 1'b1;
                        n_state = S_OUT;
                    end else begin
                        div_start = 1'b1;
                        n_neg     = acc[ACC_W-1] != r_a0[DATA_W-1];
                        n_zdiv    = 1'b0;
                        n_state   = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    if (r_neg) begin
                        n_sat = quo > ACC_W'(64'h8000_0000);
                        n_y   = n_sat ? 32'h8000_0000 : DATA_W'(0) - quo[DATA_W-1:0];
                    end else begin
                        n_sat = quo > ACC_W'(64'h7FFF_FFFF);
                        n_y   = n_sat ? 32'h7FFF_FFFF : quo[DATA_W-1:0];
                    end
                    n_state = S_WBX;
                end
            end
            S_WBX: begin
                h_we    = 1'b1;
                h_waddr = hist_addr(1'b0, int'(r_pos));
                h_wdata = r_sample;
                n_state = S_WBY;
            end
            S_WBY: begin
                h_we    = 1'b1;
                h_waddr = hist_addr(1'b1, int'(r_pos));
                h_wdata = r_y;
                n_pos   = (int'(r_pos) == MAX_ORDER - 1) ? '0 : r_pos + POS_W'(1);
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_vld || o_out.ready) begin
                    n_out_vld  = 1'b1;
                    n_out_y    = r_y;
                    n_out_sat  = r_sat;
                    n_out_zdiv = r_zdiv;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_num_ord <= '0;
            r_den_ord <= '0;
            r_pos     <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_num_ord <= n_num_ord;
            r_den_ord <= n_den_ord;
            r_pos     <= n_pos;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
        r_sample   <= n_sample;
        r_k        <= n_k;
        r_hidx     <= n_hidx;
        r_rd_kind  <= n_rd_kind;
        r_a0       <= n_a0;
        r_neg      <= n_neg;
        r_y        <= n_y;
        r_sat      <= n_sat;
        r_zdiv     <= n_zdiv;
        r_out_y    <= n_out_y;
        r_out_sat  <= n_out_sat;
        r_out_zdiv <= n_out_zdiv;
    end

    iirdf1_ram #(
        .DEPTH (CDEPTH)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (i_in.value),
        .i_raddr (c_raddr),
        .o_rdata (c_rdata)
    );

    iirdf1_ram #(
        .DEPTH (HDEPTH)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (h_wdata),
        .i_raddr (h_raddr),
        .o_rdata (h_rdata)
    );

    iirdf1_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_coef  (c_rdata),
        .i_data  ((r_rd_kind == TAP_B0) ? r_sample : h_rdata),
        .o_acc   (acc),
        .o_busy  (mac_busy)
    );

    iirdf1_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    assign i_cfg.ready        = 1'b1;
    assign i_in.ready         = r_state == S_IDLE;
    assign o_out.valid        = r_out_vld;
    assign o_out.filtered     = r_out_y;
    assign o_out.saturated    = r_out_sat;
    assign o_out.zero_divisor = r_out_zdiv;

endmodule
